// ----- sv/variable_slot_ring_allocator_unit_defines.svh -----
// Assertion macros for the slot ring allocator checker.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef VARIABLE_SLOT_RING_ALLOCATOR_UNIT_DEFINES_SVH
`define VARIABLE_SLOT_RING_ALLOCATOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VSRA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VSRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/vsra_pkg.sv -----
// Shared constants, codes and types for the slot ring allocator.
// Used by the top level, the shared adder unit and the port checker.
package vsra_pkg;

    // Ring geometry (ring size is a power of two, offsets wrap by truncation)
    localparam int RING_SIZE    = 16384;
    localparam int ALIGN_BYTES  = 64;
    localparam int HEADER_BYTES = 32;
    localparam int RING_TOTAL   = ((RING_SIZE + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int SLOTS        = RING_TOTAL / ALIGN_BYTES;

    // Field and datapath widths
    localparam int OFF_W    = 14;
    localparam int SIZE_W   = 15;
    localparam int PAY_W    = 15;
    localparam int CNT_W    = 9;
    localparam int OP_W     = 2;
    localparam int ALIGN_SH = $clog2(ALIGN_BYTES);
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int UNIT_W   = SIZE_W - ALIGN_SH;
    localparam int TOT_W    = 16;
    localparam int ALU_W    = 17;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 56;

    localparam logic [TOT_W-1:0] ALIGN_MASK = ~TOT_W'(ALIGN_BYTES - 1);

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK    = 2'd2;
    localparam logic [OP_W-1:0] OP_RECLAIM = 2'd3;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [ALU_W-1:0]   a;
        logic [ALU_W-1:0]   b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0]   result;
        logic               borrow;
    } alu_rsp_t;

endpackage

// ----- sv/vsra_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; contents are undefined until written.
module vsra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, hold data while idle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/vsra_alu.sv -----
// Shared add/subtract unit with borrow flag, driven by the sequencer.
// Depends on vsra_pkg for the request and response types.
module vsra_alu
    import vsra_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ALU_W:0] wide;

    // One add or subtract; borrow doubles as the unsigned a < b compare
    always_comb begin
        unique case (req.op)
            ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
            ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
            default: wide = '0;
        endcase
        rsp.result = wide[ALU_W-1:0];
        rsp.borrow = (req.op == ALU_SUB) && wide[ALU_W];
    end

endmodule

// ----- sv/variable_slot_ring_allocator_unit.sv -----
// Slot ring allocator: tracks a 16 KiB byte ring of variable-size slots (header plus payload,
// rounded up to 64 bytes) and takes one command beat at a time: allocate, space query, mark
// consumed, reclaim. All arithmetic runs through one shared add/subtract unit stepped by a
// small sequencer, and slot sizes and consumed flags live in two 256-entry RAMs with a
// registered read; these are undefined after reset and need no clearing pass, since only
// slots that were allocated are ever reclaimed, and the user must mark only allocated slots,
// which the block itself does not enforce. An allocate is placed at the head, or wraps with an
// end-of-ring sentinel, or fails; a reclaim frees one slot or sentinel at a time (one RAM
// read and three adder passes each) and stops at an unconsumed or empty entry. The block
// takes no new command until the current one has produced its result; a finished result
// waits in the output register and the next command is accepted meanwhile.
// Depends on vsra_pkg, vsra_alu and vsra_ram.
module variable_slot_ring_allocator_unit
    import vsra_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,  // [14:0] payload_len, [28:15] slot_offset
    input  logic [OP_W-1:0]  s_axis_tuser,  // [1:0] opcode
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,  // [13:0] granted_offset, [28:14] granted_size,
                                            // [43:29] free_space, [52:44] reclaimed_count
    output logic             m_axis_tuser   // [0] status
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] ST_FIT   = 4'd1;
    localparam logic [ST_W-1:0] ST_ROOM  = 4'd2;
    localparam logic [ST_W-1:0] ST_CMP   = 4'd3;
    localparam logic [ST_W-1:0] ST_DIR   = 4'd4;
    localparam logic [ST_W-1:0] ST_WSUB  = 4'd5;
    localparam logic [ST_W-1:0] ST_WCMP  = 4'd6;
    localparam logic [ST_W-1:0] ST_SENT  = 4'd7;
    localparam logic [ST_W-1:0] ST_WRAP  = 4'd8;
    localparam logic [ST_W-1:0] ST_MARK  = 4'd9;
    localparam logic [ST_W-1:0] ST_RCHK  = 4'd10;
    localparam logic [ST_W-1:0] ST_REVAL = 4'd11;
    localparam logic [ST_W-1:0] ST_RFREE = 4'd12;
    localparam logic [ST_W-1:0] ST_DONE  = 4'd13;

    localparam int PAD_W = OUT_W - (CNT_W + 2 * SIZE_W + OFF_W);

    // Control state
    logic [ST_W-1:0]   state_reg, state_next;
    logic [OFF_W-1:0]  head_reg, head_next;
    logic [OFF_W-1:0]  tail_reg, tail_next;
    logic [SIZE_W-1:0] free_reg, free_next;
    logic              m_valid_reg, m_valid_next;

    // Working and result registers
    logic [OP_W-1:0]   op_reg, op_next;
    logic [OFF_W-1:0]  soff_reg, soff_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [SIZE_W-1:0] room_reg, room_next;
    logic [SIZE_W-1:0] tmp_reg, tmp_next;
    logic              status_reg, status_next;
    logic [OFF_W-1:0]  goff_reg, goff_next;
    logic [SIZE_W-1:0] gsize_reg, gsize_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;
    logic              m_user_reg, m_user_next;

    // Shared unit and RAM ports
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    logic              size_we, flag_we, rd_en;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [UNIT_W-1:0] size_wdata, rd_size;
    logic              flag_wdata, rd_flag;
    logic [SIZE_W-1:0] rd_bytes;

    vsra_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    vsra_ram #(
        .WIDTH (UNIT_W),
        .DEPTH (SLOTS)
    ) u_size_ram (
        .aclk    (aclk),
        .wr_en   (size_we),
        .wr_addr (wr_addr),
        .wr_data (size_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_size)
    );

    vsra_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_flag_ram (
        .aclk    (aclk),
        .wr_en   (flag_we),
        .wr_addr (wr_addr),
        .wr_data (flag_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_flag)
    );

    assign rd_bytes      = {rd_size, ALIGN_SH'(0)};
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Sequencer: one adder pass per step, RAM writes and reads issued per state
    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        free_next    = free_reg;
        op_next      = op_reg;
        soff_next    = soff_reg;
        total_next   = total_reg;
        room_next    = room_reg;
        tmp_next     = tmp_reg;
        status_next  = status_reg;
        goff_next    = goff_reg;
        gsize_next   = gsize_reg;
        count_next   = count_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;

        alu_req    = '{op: ALU_ADD, a: '0, b: '0};
        size_we    = 1'b0;
        flag_we    = 1'b0;
        wr_addr    = head_reg[OFF_W-1:ALIGN_SH];
        size_wdata = total_reg[ALIGN_SH +: UNIT_W];
        flag_wdata = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = tail_reg[OFF_W-1:ALIGN_SH];

        unique case (state_reg)
            ST_IDLE: begin
                // Round header plus payload up to the alignment
                alu_req = '{op: ALU_ADD,
                            a: ALU_W'(s_axis_tdata[PAY_W-1:0]),
                            b: ALU_W'(HEADER_BYTES + ALIGN_BYTES - 1)};
                if (s_axis_tvalid) begin
                    op_next     = s_axis_tuser;
                    soff_next   = s_axis_tdata[PAY_W +: OFF_W];
                    total_next  = alu_rsp.result[TOT_W-1:0] & ALIGN_MASK;
                    status_next = 1'b0;
                    goff_next   = '0;
                    gsize_next  = '0;
                    count_next  = '0;
                    unique case (s_axis_tuser) inside
                        OP_ALLOC, OP_QUERY: state_next = ST_FIT;
                        OP_MARK:            state_next = ST_MARK;
                        OP_RECLAIM:         state_next = ST_RCHK;
                        default:            state_next = ST_DONE;
                    endcase
                end
            end
            ST_FIT: begin
                // Compare against free space; keep the difference for a head placement
                alu_req  = '{op: ALU_SUB, a: ALU_W'(free_reg), b: ALU_W'(total_reg)};
                tmp_next = alu_rsp.result[SIZE_W-1:0];
                if (alu_rsp.borrow || op_reg == OP_QUERY) begin
                    status_next = alu_rsp.borrow;
                    state_next  = ST_DONE;
                end else begin
                    state_next = ST_ROOM;
                end
            end
            ST_ROOM: begin
                alu_req   = '{op: ALU_SUB, a: ALU_W'(RING_TOTAL), b: ALU_W'(head_reg)};
                room_next = alu_rsp.result[SIZE_W-1:0];
                state_next = ST_CMP;
            end
            ST_CMP: begin
                alu_req    = '{op: ALU_SUB, a: ALU_W'(room_reg), b: ALU_W'(total_reg)};
                state_next = alu_rsp.borrow ? ST_WSUB : ST_DIR;
            end
            ST_DIR: begin
                // Place slot at the head and advance it
                size_we    = 1'b1;
                flag_we    = 1'b1;
                alu_req    = '{op: ALU_ADD, a: ALU_W'(head_reg), b: ALU_W'(total_reg)};
                head_next  = alu_rsp.result[OFF_W-1:0];
                free_next  = tmp_reg;
                goff_next  = head_reg;
                gsize_next = total_reg[SIZE_W-1:0];
                state_next = ST_DONE;
            end
            ST_WSUB: begin
                alu_req    = '{op: ALU_SUB, a: ALU_W'(free_reg), b: ALU_W'(room_reg)};
                tmp_next   = alu_rsp.result[SIZE_W-1:0];
                state_next = ST_WCMP;
            end
            ST_WCMP: begin
                // Both the tail gap and the slot must fit
                alu_req  = '{op: ALU_SUB, a: ALU_W'(tmp_reg), b: ALU_W'(total_reg)};
                tmp_next = alu_rsp.result[SIZE_W-1:0];
                if (alu_rsp.borrow) begin
                    status_next = 1'b1;
                    state_next  = ST_DONE;
                end else begin
                    state_next = ST_SENT;
                end
            end
            ST_SENT: begin
                // Cover the gap to the ring end with a consumed sentinel
                size_we    = 1'b1;
                flag_we    = 1'b1;
                size_wdata = room_reg[ALIGN_SH +: UNIT_W];
                flag_wdata = 1'b1;
                state_next = ST_WRAP;
            end
            ST_WRAP: begin
                size_we    = 1'b1;
                flag_we    = 1'b1;
                wr_addr    = '0;
                head_next  = total_reg[OFF_W-1:0];
                free_next  = tmp_reg;
                goff_next  = '0;
                gsize_next = total_reg[SIZE_W-1:0];
                state_next = ST_DONE;
            end
            ST_MARK: begin
                flag_we    = 1'b1;
                flag_wdata = 1'b1;
                wr_addr    = soff_reg[OFF_W-1:ALIGN_SH];
                state_next = ST_DONE;
            end
            ST_RCHK: begin
                // Stop when the ring is empty or a full lap was freed, else read at tail
                alu_req = '{op: ALU_SUB, a: ALU_W'(free_reg), b: ALU_W'(RING_TOTAL)};
                if (!alu_rsp.borrow || count_reg == CNT_W'(SLOTS)) begin
                    state_next = ST_DONE;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_REVAL;
                end
            end
            ST_REVAL: begin
                // Stop at an unconsumed or empty entry, else advance the tail
                alu_req   = '{op: ALU_ADD, a: ALU_W'(tail_reg), b: ALU_W'(rd_bytes)};
                if (!rd_flag || rd_size == '0) begin
                    state_next = ST_DONE;
                end else begin
                    tail_next  = alu_rsp.result[OFF_W-1:0];
                    state_next = ST_RFREE;
                end
            end
            ST_RFREE: begin
                // Return the bytes, saturating at the ring size
                alu_req = '{op: ALU_ADD, a: ALU_W'(free_reg), b: ALU_W'(rd_bytes)};
                if (alu_rsp.result > ALU_W'(RING_TOTAL)) begin
                    free_next = SIZE_W'(RING_TOTAL);
                end else begin
                    free_next = alu_rsp.result[SIZE_W-1:0];
                end
                count_next = count_reg + 1'b1;
                state_next = ST_RCHK;
            end
            ST_DONE: begin
                // Hand the result to the output register once it is free
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {PAD_W'(0), count_reg, free_reg, gsize_reg, goff_reg};
                    m_user_next  = status_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            free_reg    <= SIZE_W'(RING_TOTAL);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and result registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        soff_reg   <= soff_next;
        total_reg  <= total_next;
        room_reg   <= room_next;
        tmp_reg    <= tmp_next;
        status_reg <= status_next;
        goff_reg   <= goff_next;
        gsize_reg  <= gsize_next;
        count_reg  <= count_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule

// ----- sv/vsra_checker.sv -----
// Port-level checker for the slot ring allocator, bound to the top level.
// Depends on vsra_pkg and the assertion macros header.
`include "variable_slot_ring_allocator_unit_defines.svh"

module vsra_checker
    import vsra_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tuser
);

    localparam int GSIZE_LSB = OFF_W;
    localparam int FREE_LSB  = OFF_W + SIZE_W;
    localparam int CNT_LSB   = OFF_W + 2 * SIZE_W;

    logic [SIZE_W-1:0] free_space;
    logic [SIZE_W-1:0] granted_size;

    assign free_space   = m_axis_tdata[FREE_LSB +: SIZE_W];
    assign granted_size = m_axis_tdata[GSIZE_LSB +: SIZE_W];

    // A stalled result beat holds
    `VSRA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

    // An accepted command is worked on before the next one is taken
    `VSRA_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "command accepted on back-to-back cycles")

    // A failed request grants nothing and frees nothing
    `VSRA_ASSERT_NOW(a_fail_clean, m_axis_tvalid && m_axis_tuser, m_axis_tdata[OFF_W-1:0] == '0 && granted_size == '0 && m_axis_tdata[CNT_LSB +: CNT_W] == '0, "failed request reports a grant")

    // Free space never exceeds the ring, and grants are aligned
    `VSRA_ASSERT_NOW(a_free_bound, m_axis_tvalid, free_space <= SIZE_W'(RING_TOTAL) && granted_size[ALIGN_SH-1:0] == '0, "free space or granted size out of range")

endmodule

bind variable_slot_ring_allocator_unit vsra_checker u_vsra_checker (.*);
